// ===== design/evsc_pkg.sv =====
// Shared types, constants and helper functions of the volume and source controller.
`default_nettype none

package evsc_pkg;

    localparam int unsigned VOL_W = 16;
    localparam int unsigned CFG_VOL_W = 15;
    localparam int unsigned SLACK_W = 10;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned SRC_W = 2;
    localparam int unsigned LED_W = 3;
    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LEVEL_SHIFT_DEF = 3;

    localparam logic signed [CFG_VOL_W-1:0] VOL_MIN_RST = 15'sd0;
    localparam logic signed [CFG_VOL_W-1:0] VOL_MAX_RST = 15'sd2040;
    localparam logic [SLACK_W-1:0] TRAVEL_MARGIN_RST = 10'd100;
    localparam logic [DELAY_W-1:0] CHANGE_HOLD_RST = 16'd1000;
    localparam logic [DELAY_W-1:0] BOOT_HOLD_RST = 16'd2000;
    localparam logic [SRC_W-1:0] NUM_SOURCES_RST = 2'd3;

    typedef enum logic [1:0] {
        CMD_ENCODER = 2'd0,
        CMD_BUTTON  = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOL_MIN       = 3'd0,
        REG_VOL_MAX       = 3'd1,
        REG_TRAVEL_MARGIN = 3'd2,
        REG_CHANGE_HOLD   = 3'd3,
        REG_BOOT_HOLD     = 3'd4,
        REG_NUM_SOURCES   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [VOL_W-1:0]   volume_word;
        logic signed [LEVEL_W-1:0] dac_level;
        logic                      dac_mute;
    } vol_result_t;

    typedef struct packed {
        logic             amp_mute;
        logic [SRC_W-1:0] source_sel;
        logic [LED_W-1:0] led_mask;
        logic             settings_changed;
    } src_result_t;

    // Gray phase of the two encoder channels.
    function automatic logic [1:0] gray_phase(input logic a, input logic b);
        logic [1:0] p;
        unique case ({a, b})
            2'b00: p = 2'd0;
            2'b10: p = 2'd1;
            2'b11: p = 2'd2;
            default: p = 2'd3;
        endcase
        return p;
    endfunction

    // Next source, wrapping at the source count; a count of zero acts as one.
    function automatic logic [SRC_W-1:0] next_source(input logic [SRC_W-1:0] cur,
                                                     input logic [SRC_W-1:0] n);
        logic [SRC_W-1:0] inc;
        logic [SRC_W-1:0] r;
        inc = cur + 2'd1;
        unique case (n)
            2'd2: r = {1'b0, inc[0]};
            2'd3: r = (inc == 2'd3) ? 2'd0 : inc;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/evsc_volume.sv =====
// Encoder decoding, saturating volume position, DAC level and DAC mute.
`default_nettype none

module evsc_volume
    import evsc_pkg::*;
#(
    parameter int unsigned LEVEL_SHIFT = LEVEL_SHIFT_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step_en,
    input  wire logic                        is_enc,
    input  wire logic                        enc_a,
    input  wire logic                        enc_b,
    input  wire logic signed [CFG_VOL_W-1:0] vol_min,
    input  wire logic signed [CFG_VOL_W-1:0] vol_max,
    input  wire logic        [SLACK_W-1:0]   travel_margin,
    output vol_result_t                      res
);

    localparam int unsigned EXT_W = VOL_W + 1;
    localparam logic signed [EXT_W-1:0] LEVEL_HI = 17'sd2047;
    localparam logic signed [EXT_W-1:0] LEVEL_LO = -17'sd2048;

    logic signed [VOL_W-1:0] pos_reg;
    logic signed [VOL_W-1:0] pos_next;
    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic                    dac_mute_reg;
    logic                    dac_mute_next;

    logic [1:0]              phase;
    logic signed [EXT_W-1:0] pos_ext;
    logic signed [EXT_W-1:0] min_ext;
    logic signed [EXT_W-1:0] max_ext;
    logic signed [EXT_W-1:0] slack_ext;
    logic signed [EXT_W-1:0] lo_bound;
    logic signed [EXT_W-1:0] hi_bound;
    logic signed [EXT_W-1:0] new_ext;
    logic signed [EXT_W-1:0] clamped;
    logic signed [EXT_W-1:0] shifted;
    logic signed [LEVEL_W-1:0] level;

    always_comb
    begin
        phase     = gray_phase(enc_a, enc_b);
        pos_ext   = {pos_reg[VOL_W-1], pos_reg};
        min_ext   = {{(EXT_W-CFG_VOL_W){vol_min[CFG_VOL_W-1]}}, vol_min};
        max_ext   = {{(EXT_W-CFG_VOL_W){vol_max[CFG_VOL_W-1]}}, vol_max};
        slack_ext = {{(EXT_W-SLACK_W){1'b0}}, travel_margin};
        lo_bound  = min_ext - slack_ext;
        hi_bound  = max_ext + slack_ext;

        pos_next      = pos_reg;
        phase_next    = phase_reg;
        dac_mute_next = dac_mute_reg;
        if (is_enc)
        begin
            new_ext = pos_ext;
            if ((phase_reg + 2'd1) == phase && pos_ext > lo_bound)
            begin
                new_ext = pos_ext - 17'sd1;
            end
            else if ((phase + 2'd1) == phase_reg && pos_ext < hi_bound)
            begin
                new_ext = pos_ext + 17'sd1;
            end
            pos_next      = new_ext[VOL_W-1:0];
            phase_next    = phase;
            dac_mute_next = (new_ext >= max_ext);
        end

        new_ext = {pos_next[VOL_W-1], pos_next};
        clamped = (new_ext <= min_ext) ? min_ext : new_ext;
        shifted = clamped >>> LEVEL_SHIFT;
        if (shifted > LEVEL_HI)
        begin
            level = LEVEL_HI[LEVEL_W-1:0];
        end
        else if (shifted < LEVEL_LO)
        begin
            level = LEVEL_LO[LEVEL_W-1:0];
        end
        else
        begin
            level = shifted[LEVEL_W-1:0];
        end

        res.volume_word = pos_next;
        res.dac_level   = level;
        res.dac_mute    = dac_mute_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= {VOL_MAX_RST[CFG_VOL_W-1], VOL_MAX_RST};
            phase_reg    <= 2'd0;
            dac_mute_reg <= 1'b1;
        end
        else if (step_en)
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            dac_mute_reg <= dac_mute_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/evsc_source.sv =====
// Source selection, amplifier mute and mute countdown.
`default_nettype none

module evsc_source
    import evsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  cmd_t                    cmd,
    input  wire logic [DELAY_W-1:0] change_hold,
    input  wire logic [SRC_W-1:0]   num_sources,
    output src_result_t             res
);

    logic [SRC_W-1:0]   src_reg;
    logic [SRC_W-1:0]   src_next;
    logic               amp_mute_reg;
    logic               amp_mute_next;
    logic [DELAY_W-1:0] count_reg;
    logic [DELAY_W-1:0] count_next;
    logic               armed_reg;
    logic               armed_next;
    logic               changed;
    logic [DELAY_W-1:0] count_dec;

    always_comb
    begin
        src_next      = src_reg;
        amp_mute_next = amp_mute_reg;
        count_next    = count_reg;
        armed_next    = armed_reg;
        changed       = 1'b0;
        count_dec     = (count_reg != '0) ? count_reg - 16'd1 : count_reg;
        unique case (cmd)
            CMD_BUTTON:
            begin
                amp_mute_next = 1'b1;
                count_next    = change_hold;
                armed_next    = 1'b1;
                src_next      = next_source(src_reg, num_sources);
                changed       = 1'b1;
            end
            CMD_TICK:
            begin
                count_next = count_dec;
                if (armed_reg && count_dec == '0)
                begin
                    amp_mute_next = 1'b0;
                    armed_next    = 1'b0;
                end
            end
            CMD_ENCODER, CMD_NONE:
            begin
            end
        endcase

        res.amp_mute         = amp_mute_next;
        res.source_sel       = src_next;
        res.led_mask         = amp_mute_next ? 3'd0 : (3'd1 << src_next);
        res.settings_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg      <= '0;
            amp_mute_reg <= 1'b1;
            count_reg    <= BOOT_HOLD_RST;
            armed_reg    <= 1'b1;
        end
        else if (step_en)
        begin
            src_reg      <= src_next;
            amp_mute_reg <= amp_mute_next;
            count_reg    <= count_next;
            armed_reg    <= armed_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/encoder_volume_source_control.sv =====
// Top level of the preamp front-panel volume and source controller.
`default_nettype none

// Each accepted word is an encoder sample, a source-button press or a millisecond
// tick, and yields exactly one result word with the state after that event. The
// block takes one word per cycle unless out_ready holds the result register full;
// an accepted word is loaded into the input register, and when the result register
// is free its result is loaded there, with all state updates done in the single
// logic pass between them. The mute length after reset is fixed by reset, so
// writes to register 4 are accepted but have no effect.
module encoder_volume_source_control
    import evsc_pkg::*;
#(
    parameter int unsigned LEVEL_SHIFT = LEVEL_SHIFT_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   command,
    input  wire logic                         enc_a,
    input  wire logic                         enc_b,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [VOL_W-1:0]           volume_word,
    output logic signed [LEVEL_W-1:0]         dac_level,
    output logic                              dac_mute,
    output logic                              amp_mute,
    output logic        [SRC_W-1:0]           source_sel,
    output logic        [LED_W-1:0]           led_mask,
    output logic                              settings_changed,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic   [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic   [CFG_DATA_W-1:0]      cfg_data
);

    logic signed [CFG_VOL_W-1:0] vol_min_reg;
    logic signed [CFG_VOL_W-1:0] vol_max_reg;
    logic [SLACK_W-1:0]          travel_margin_reg;
    logic [DELAY_W-1:0]          change_hold_reg;
    logic [SRC_W-1:0]            num_sources_reg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    cmd_t       s1_cmd_reg;
    logic       s1_a_reg;
    logic       s1_b_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       step_en;
    logic       in_fire;

    vol_result_t vol_res;
    src_result_t src_res;
    vol_result_t vol_out_reg;
    src_result_t src_out_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign step_en   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_min_reg       <= VOL_MIN_RST;
            vol_max_reg       <= VOL_MAX_RST;
            travel_margin_reg <= TRAVEL_MARGIN_RST;
            change_hold_reg   <= CHANGE_HOLD_RST;
            num_sources_reg   <= NUM_SOURCES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VOL_MIN:       vol_min_reg       <= cfg_data[CFG_VOL_W-1:0];
                REG_VOL_MAX:       vol_max_reg       <= cfg_data[CFG_VOL_W-1:0];
                REG_TRAVEL_MARGIN: travel_margin_reg <= cfg_data[SLACK_W-1:0];
                REG_CHANGE_HOLD:   change_hold_reg   <= cfg_data;
                REG_NUM_SOURCES:   num_sources_reg   <= cfg_data[SRC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg <= cmd_t'(command);
            s1_a_reg   <= enc_a;
            s1_b_reg   <= enc_b;
        end
        if (step_en)
        begin
            vol_out_reg <= vol_res;
            src_out_reg <= src_res;
        end
    end

    evsc_volume #(
        .LEVEL_SHIFT (LEVEL_SHIFT)
    ) u_volume (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .is_enc        (s1_cmd_reg == CMD_ENCODER),
        .enc_a         (s1_a_reg),
        .enc_b         (s1_b_reg),
        .vol_min       (vol_min_reg),
        .vol_max       (vol_max_reg),
        .travel_margin (travel_margin_reg),
        .res           (vol_res)
    );

    evsc_source u_source (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .cmd         (s1_cmd_reg),
        .change_hold (change_hold_reg),
        .num_sources (num_sources_reg),
        .res         (src_res)
    );

    assign out_valid        = out_valid_reg;
    assign volume_word      = vol_out_reg.volume_word;
    assign dac_level        = vol_out_reg.dac_level;
    assign dac_mute         = vol_out_reg.dac_mute;
    assign amp_mute         = src_out_reg.amp_mute;
    assign source_sel       = src_out_reg.source_sel;
    assign led_mask         = src_out_reg.led_mask;
    assign settings_changed = src_out_reg.settings_changed;

endmodule

`default_nettype wire

// ===== tb/encoder_volume_source_control_tb.sv =====
// Self-checking testbench of the preamp volume and source controller with a built-in predictor.
`default_nettype none

module encoder_volume_source_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import evsc_pkg::*;

    localparam int LVL_SHIFT = LEVEL_SHIFT_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 195;
    localparam int VOL_LOW_END = -16384;
    localparam int VOL_HIGH_END = 16383;

    typedef struct packed {
        logic signed [VOL_W-1:0]   volume_word;
        logic signed [LEVEL_W-1:0] dac_level;
        logic                      dac_mute;
        logic                      amp_mute;
        logic [SRC_W-1:0]          source_sel;
        logic [LED_W-1:0]          led_mask;
        logic                      settings_changed;
    } panel_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_REG,
        ROW_UNMUTE_WAIT
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cmd_t                   cmd;
        logic                   a;
        logic                   b;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     typed;
        panel_t                 want;
    } script_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] command = CMD_NONE;
    logic enc_a = 1'b0;
    logic enc_b = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_VOL_MIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic in_ready;
    logic out_valid;
    logic cfg_ready;
    logic signed [VOL_W-1:0] volume_word;
    logic signed [LEVEL_W-1:0] dac_level;
    logic dac_mute;
    logic amp_mute;
    logic [SRC_W-1:0] source_sel;
    logic [LED_W-1:0] led_mask;
    logic settings_changed;

    encoder_volume_source_control #(
        .LEVEL_SHIFT(LVL_SHIFT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .enc_a(enc_a),
        .enc_b(enc_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .volume_word(volume_word),
        .dac_level(dac_level),
        .dac_mute(dac_mute),
        .amp_mute(amp_mute),
        .source_sel(source_sel),
        .led_mask(led_mask),
        .settings_changed(settings_changed),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted panel state and register copies.
    int vol_pos;
    logic [1:0] enc_phase;
    bit dac_muted;
    bit amp_muted;
    bit unmute_armed;
    int unsigned src_now;
    int unsigned countdown;
    int vmin;
    int vmax;
    int unsigned slack;
    int unsigned mdelay;
    int unsigned nsrc;

    panel_t results_due[$];
    script_row_t script[$];
    int fails = 0;
    int words_sent = 0;
    int burst_left = 0;
    bit sending = 1'b0;
    bit cfg_open = 1'b0;

    int rx_mode = 0;
    int rx_seg_left = 0;
    int rx_hold_left = 0;
    logic rx_next;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [1:0] phase_of(input logic a, input logic b);
        case ({a, b})
            2'b00: return 2'd0;
            2'b10: return 2'd1;
            2'b11: return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] channels_of(input logic [1:0] ph);
        case (ph)
            2'd0: return 2'b00;
            2'd1: return 2'b10;
            2'd2: return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] vol_data(input int v);
        logic [CFG_DATA_W-1:0] d;
        d = {1'($urandom_range(0, 1)), v[CFG_VOL_W-1:0]};
        return d;
    endfunction

    function automatic panel_t panel(input int vol, input int lvl, input bit dm, input bit am,
                                     input int src, input int led, input bit chg);
        panel_t p;
        p.volume_word = vol[VOL_W-1:0];
        p.dac_level = lvl[LEVEL_W-1:0];
        p.dac_mute = dm;
        p.amp_mute = am;
        p.source_sel = src[SRC_W-1:0];
        p.led_mask = led[LED_W-1:0];
        p.settings_changed = chg;
        return p;
    endfunction

    function automatic void add_word(input cmd_t c, input logic a, input logic b,
                                     input bit typed, input panel_t want);
        script_row_t row;
        row.kind = ROW_WORD;
        row.cmd = c;
        row.a = a;
        row.b = b;
        row.idx = REG_VOL_MIN;
        row.data = '0;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row.kind = ROW_REG;
        row.cmd = CMD_NONE;
        row.a = 1'b0;
        row.b = 1'b0;
        row.idx = idx;
        row.data = data;
        row.typed = 1'b0;
        row.want = '0;
        script.push_back(row);
    endfunction

    task automatic apply_event(input cmd_t c, input logic a, input logic b, output panel_t r);
        logic [1:0] ph;
        int lo;
        int hi;
        int v;
        int lv;
        int unsigned n;
        bit chg;
        chg = 1'b0;
        case (c)
            CMD_ENCODER:
            begin
                ph = phase_of(a, b);
                lo = vmin - int'(slack);
                hi = vmax + int'(slack);
                if (ph == 2'(enc_phase + 2'd1) && vol_pos > lo)
                    vol_pos--;
                if (ph == 2'(enc_phase - 2'd1) && vol_pos < hi)
                    vol_pos++;
                dac_muted = (vol_pos >= vmax);
                enc_phase = ph;
            end
            CMD_BUTTON:
            begin
                n = (nsrc == 0) ? 1 : nsrc;
                amp_muted = 1'b1;
                countdown = mdelay;
                unmute_armed = 1'b1;
                src_now = (src_now + 1) % n;
                chg = 1'b1;
            end
            CMD_TICK:
            begin
                if (countdown > 0)
                    countdown--;
                if (unmute_armed && countdown == 0)
                begin
                    amp_muted = 1'b0;
                    unmute_armed = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        v = (vol_pos <= vmin) ? vmin : vol_pos;
        lv = v >>> LVL_SHIFT;
        if (lv > 2047)
            lv = 2047;
        if (lv < -2048)
            lv = -2048;
        r.volume_word = vol_pos[VOL_W-1:0];
        r.dac_level = lv[LEVEL_W-1:0];
        r.dac_mute = dac_muted;
        r.amp_mute = amp_muted;
        r.source_sel = src_now[SRC_W-1:0];
        r.led_mask = amp_muted ? '0 : LED_W'(1 << src_now);
        r.settings_changed = chg;
    endtask

    task automatic send_word(input cmd_t c, input logic a, input logic b,
                             input bit typed, input panel_t want);
        int gap;
        int pick;
        panel_t pred;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            gap = (pick < 3) ? 0 : (pick < 8) ? $urandom_range(1, 3) : $urandom_range(4, 8);
            if (gap != 0)
            begin
                if (sending)
                begin
                    in_valid <= 1'b0;
                    sending = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        sending = 1'b1;
        command <= c;
        enc_a <= a;
        enc_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_event(c, a, b, pred);
        results_due.push_back(typed ? want : pred);
        burst_left--;
        words_sent++;
    endtask

    task automatic send(input cmd_t c, input logic a, input logic b);
        send_word(c, a, b, 1'b0, '0);
    endtask

    // One detent of the knob; up raises the volume word.
    task automatic turn(input bit up);
        logic [1:0] ab;
        ab = channels_of(up ? 2'(enc_phase - 2'd1) : 2'(enc_phase + 2'd1));
        send(CMD_ENCODER, ab[1], ab[0]);
    endtask

    task automatic quiesce();
        if (sending)
        begin
            in_valid <= 1'b0;
            sending = 1'b0;
        end
        burst_left = 0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_open = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_VOL_MIN: vmin = int'($signed(data[CFG_VOL_W-1:0]));
            REG_VOL_MAX: vmax = int'($signed(data[CFG_VOL_W-1:0]));
            REG_TRAVEL_MARGIN: slack = 32'(data[SLACK_W-1:0]);
            REG_CHANGE_HOLD: mdelay = 32'(data);
            REG_NUM_SOURCES: nsrc = 32'(data[SRC_W-1:0]);
            // The initial mute length only matters at reset, so a write changes nothing.
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rx_seg_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_seg_left = $urandom_range(16, 240);
        end
        else
            rx_seg_left--;
        case (rx_mode)
            0: rx_next = 1'b1;
            1: rx_next = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_hold_left == 0)
                begin
                    rx_next = ~out_ready;
                    rx_hold_left = rx_next ? $urandom_range(1, 4) : $urandom_range(1, 12);
                end
                else
                begin
                    rx_next = out_ready;
                    rx_hold_left--;
                end
            end
        endcase
        out_ready <= rx_next;
    end

    always @(posedge clk)
    begin
        panel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result word arrived with no expectation waiting");
                fails++;
            end
            else
            begin
                want = results_due.pop_front();
                if (volume_word !== want.volume_word)
                begin
                    $error("volume_word: expected %0d, got %0d", want.volume_word, volume_word);
                    fails++;
                end
                if (dac_level !== want.dac_level)
                begin
                    $error("dac_level: expected %0d, got %0d", want.dac_level, dac_level);
                    fails++;
                end
                if (dac_mute !== want.dac_mute)
                begin
                    $error("dac_mute: expected %0d, got %0d", want.dac_mute, dac_mute);
                    fails++;
                end
                if (amp_mute !== want.amp_mute)
                begin
                    $error("amp_mute: expected %0d, got %0d", want.amp_mute, amp_mute);
                    fails++;
                end
                if (source_sel !== want.source_sel)
                begin
                    $error("source_sel: expected %0d, got %0d", want.source_sel, source_sel);
                    fails++;
                end
                if (led_mask !== want.led_mask)
                begin
                    $error("led_mask: expected %0d, got %0d", want.led_mask, led_mask);
                    fails++;
                end
                if (settings_changed !== want.settings_changed)
                begin
                    $error("settings_changed: expected %0d, got %0d",
                           want.settings_changed, settings_changed);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        script_row_t row;
        int n_words;
        int r;
        int len;
        int c;
        bit up;
        bit hi_end;

        vmin = int'(VOL_MIN_RST);
        vmax = int'(VOL_MAX_RST);
        slack = 32'(TRAVEL_MARGIN_RST);
        mdelay = 32'(CHANGE_HOLD_RST);
        nsrc = 32'(NUM_SOURCES_RST);
        vol_pos = int'(VOL_MAX_RST);
        enc_phase = 2'd0;
        dac_muted = 1'b1;
        amp_muted = 1'b1;
        unmute_armed = 1'b1;
        src_now = 0;
        countdown = 32'(BOOT_HOLD_RST);

        add_word(CMD_NONE, 1'b1, 1'b1, 1'b1, panel(2040, 255, 1, 1, 0, 0, 0));
        add_word(CMD_TICK, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b1, 1'b0, 1'b1, panel(2039, 254, 0, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b0, 1'b1, 1'b1, panel(2041, 255, 1, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b1, 1'b0, 1'b1, panel(2041, 255, 1, 1, 0, 0, 0));
        add_word(CMD_ENCODER, 1'b1, 1'b1, 1'b1, panel(2040, 255, 1, 1, 0, 0, 0));
        // A short mute after three presses brings the source back to zero.
        add_reg(REG_CHANGE_HOLD, 16'd3);
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b0, '0);
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b0, '0);
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b0, '0);
        row.kind = ROW_UNMUTE_WAIT;
        script.push_back(row);
        add_word(CMD_NONE, 1'b0, 1'b1, 1'b1, panel(2040, 255, 1, 0, 0, 1, 0));
        add_word(CMD_BUTTON, 1'b1, 1'b0, 1'b1, panel(2040, 255, 1, 1, 1, 0, 1));
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 2, 0, 1));
        add_word(CMD_BUTTON, 1'b1, 1'b1, 1'b1, panel(2040, 255, 1, 1, 0, 0, 1));
        add_reg(REG_CHANGE_HOLD, 16'h0000);
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 1, 0, 1));
        add_word(CMD_TICK, 1'b1, 1'b1, 1'b1, panel(2040, 255, 1, 0, 1, 2, 0));
        add_word(CMD_TICK, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 0, 1, 2, 0));
        add_reg(REG_NUM_SOURCES, 16'h0000);
        add_word(CMD_BUTTON, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 1, 0, 0, 1));
        add_word(CMD_TICK, 1'b0, 1'b0, 1'b1, panel(2040, 255, 1, 0, 0, 1, 0));
        add_reg(REG_TRAVEL_MARGIN, 16'h0000);
        add_word(CMD_ENCODER, 1'b1, 1'b0, 1'b1, panel(2040, 255, 1, 0, 0, 1, 0));
        add_reg(REG_VOL_MIN, 16'h3FFF);
        add_word(CMD_ENCODER, 1'b0, 1'b0, 1'b1, panel(2040, 2047, 1, 0, 0, 1, 0));
        add_reg(REG_SPARE, 16'hFFFF);
        add_reg(REG_BOOT_HOLD, 16'h0000);
        add_word(CMD_NONE, 1'b0, 1'b0, 1'b1, panel(2040, 2047, 1, 0, 0, 1, 0));
        add_reg(REG_VOL_MIN, 16'hC000);
        add_reg(REG_VOL_MAX, 16'hBFFF);
        add_reg(REG_TRAVEL_MARGIN, 16'hFFFF);
        add_reg(REG_CHANGE_HOLD, 16'hFFFF);
        add_reg(REG_NUM_SOURCES, 16'hFFFF);
        add_word(CMD_ENCODER, 1'b1, 1'b0, 1'b0, '0);
        add_word(CMD_BUTTON, 1'b1, 1'b1, 1'b0, '0);
        add_word(CMD_TICK, 1'b0, 1'b1, 1'b0, '0);
        add_word(CMD_ENCODER, 1'b1, 1'b1, 1'b0, '0);
        add_word(CMD_ENCODER, 1'b0, 1'b1, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_BOOT_HOLD, 16'h0001);

        foreach (script[i])
        begin
            row = script[i];
            case (row.kind)
                ROW_REG:
                begin
                    quiesce();
                    write_reg(row.idx, row.data);
                end
                ROW_WORD: send_word(row.cmd, row.a, row.b, row.typed, row.want);
                default:
                    while (amp_muted)
                        send(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
        end

        // Full travel to the top saturation point and then down to the bottom one.
        quiesce();
        c = vol_pos;
        write_reg(REG_VOL_MIN, vol_data(c - 40));
        write_reg(REG_VOL_MAX, vol_data(c + 40));
        write_reg(REG_TRAVEL_MARGIN, 16'd20);
        while (vol_pos < vmax + int'(slack))
            turn(1'b1);
        repeat (20) turn(1'b1);
        while (vol_pos > vmin - int'(slack))
            turn(1'b0);
        repeat (20) turn(1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            quiesce();
            case (p % 4)
                0:
                begin
                    hi_end = (p != 0);
                    write_reg(REG_VOL_MIN, vol_data(hi_end ? VOL_HIGH_END : VOL_LOW_END));
                    write_reg(REG_VOL_MAX, vol_data(hi_end ? VOL_HIGH_END : VOL_LOW_END));
                    write_reg(REG_TRAVEL_MARGIN, hi_end ? 16'd1023 : 16'd0);
                    write_reg(REG_CHANGE_HOLD, hi_end ? 16'hFFFF : 16'h0000);
                    write_reg(REG_NUM_SOURCES, hi_end ? 16'd3 : 16'd1);
                end
                1, 3:
                begin
                    c = vol_pos;
                    if (c < VOL_LOW_END + 64)
                        c = VOL_LOW_END + 64;
                    if (c > VOL_HIGH_END - 64)
                        c = VOL_HIGH_END - 64;
                    write_reg(REG_VOL_MIN, vol_data(c - int'($urandom_range(0, 40))));
                    write_reg(REG_VOL_MAX, vol_data(c + int'($urandom_range(0, 40))));
                    write_reg(REG_TRAVEL_MARGIN, 16'($urandom_range(0, 6)));
                    write_reg(REG_CHANGE_HOLD, 16'($urandom_range(0, 12)));
                    write_reg(REG_NUM_SOURCES, 16'($urandom_range(0, 3)));
                end
                default:
                begin
                    write_reg(REG_VOL_MIN, vol_data(int'($urandom_range(0, 32767)) - 16384));
                    write_reg(REG_VOL_MAX, vol_data(int'($urandom_range(0, 32767)) - 16384));
                    write_reg(REG_TRAVEL_MARGIN, 16'($urandom));
                    write_reg(REG_CHANGE_HOLD, 16'($urandom_range(0, 30)));
                    write_reg(REG_NUM_SOURCES, 16'($urandom));
                end
            endcase
            write_reg(REG_BOOT_HOLD, 16'($urandom));

            n_words = words_sent + WORDS_PER_PHASE;
            while (words_sent < n_words)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    up = 1'($urandom_range(0, 1));
                    len = $urandom_range(1, 40);
                    repeat (len) turn(up);
                end
                else if (r < 70)
                    send(CMD_ENCODER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else if (r < 78)
                    send(CMD_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else if (r < 95)
                    repeat ($urandom_range(1, 15))
                        send(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    send(CMD_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        quiesce();
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/evsc_pkg.sv
design/evsc_volume.sv
design/evsc_source.sv
design/encoder_volume_source_control.sv
tb/encoder_volume_source_control_tb.sv
